[rtl/rgbg_pkg.sv]
// ----------------------------------------------------------------------------
// rgbg_pkg: shared types, constants and table functions
// Fixed-point tables for the stretch/boost/power-law pixel corrector.
// ----------------------------------------------------------------------------
`default_nettype none
package rgbg_pkg;

  localparam int BOOST_FRAC_BITS_DEF = 8;
  localparam int CHAN_W  = 8;
  localparam int BOOST_W = 12;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int NUM_W   = 27;  // width of 255 * log difference in Q16
  localparam int RCP_W   = 29;  // width of floor(2^28 / inverse_gamma)
  localparam int RCP_SH  = 28;
  localparam int V_W     = 31;  // Q30 value up to 1.0
  localparam int ROOTS   = 16;
  localparam int LAT     = 25;  // pipeline depth in stages

  // floor(n / 255) as (n * DIV255_MUL) >> DIV255_SH, exact for n < 2^17
  localparam logic [18:0] DIV255_MUL = 19'd263173;
  localparam int          DIV255_SH  = 26;

  localparam logic [0:0] REG_INV_GAMMA  = 1'b0;
  localparam logic [0:0] REG_LOW_CUTOFF = 1'b1;

  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^-(2^-(i+1)) in Q30
  function automatic logic [29:0] root_q30(int idx);
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int i = 1; i < ROOTS; i++) begin
      if (i <= idx) r = isqrt64(r << 30);
    end
    return r[29:0];
  endfunction

  function automatic logic [31:0] log2_q16(logic [7:0] x);
    logic [31:0] p;
    logic [31:0] f;
    logic [63:0] m;
    p = 32'd0;
    f = 32'd0;
    for (int i = 0; i < 7; i++) begin
      if ((({24'd0, x}) >> (p + 32'd1)) != 32'd0) p = p + 32'd1;
    end
    m = 64'({56'd0, x}) << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        f = f | 32'd1;
        m = m >> 1;
      end
    end
    return (p << 16) | f;
  endfunction

  // 255 * (log2(255) - log2(b)) in Q16 for b in 1..254
  function automatic logic [NUM_W-1:0] num_val(logic [7:0] b);
    logic [31:0] d;
    if (b == 8'd0 || b == 8'd255) return '0;
    d = log2_q16(8'd255) - log2_q16(b);
    return NUM_W'(d * 32'd255);
  endfunction

  // floor(2^28 / d) by shift-subtract
  function automatic logic [RCP_W-1:0] recip_val(logic [7:0] d);
    logic [RCP_W-1:0] num;
    logic [RCP_W-1:0] quo;
    logic [9:0]       rem;
    if (d == 8'd0) return '0;
    num = RCP_W'(1) << RCP_SH;
    quo = '0;
    rem = '0;
    for (int i = RCP_W - 1; i >= 0; i--) begin
      rem = {rem[8:0], num[i]};
      quo = quo << 1;
      if (rem >= {2'd0, d}) begin
        rem = rem - {2'd0, d};
        quo = quo | RCP_W'(1);
      end
    end
    return quo;
  endfunction

endpackage
`default_nettype wire

[rtl/rgbg_if.sv]
// ----------------------------------------------------------------------------
// rgbg_in_if / rgbg_out_if: pixel channels
// Valid/ready channels carrying input pixels and corrected pixels.
// ----------------------------------------------------------------------------
`default_nettype none
interface rgbg_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [11:0] boost;
  modport source(output valid, output red_in, output green_in, output blue_in,
                 output boost, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               input boost, output ready);
endinterface

interface rgbg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source(output valid, output red_out, output green_out, output blue_out,
                 input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               output ready);
endinterface
`default_nettype wire

[rtl/rgbg_chan.sv]
// ----------------------------------------------------------------------------
// rgbg_chan: one color channel datapath
// Stretch, boost, exponent division and power-law product, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbg_chan #(
  parameter int BOOST_FRAC_BITS = rgbg_pkg::BOOST_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rgbg_pkg::CHAN_W-1:0]  chan_in,
  input  wire logic [rgbg_pkg::BOOST_W-1:0] boost,
  input  wire logic [7:0]                   low_cutoff,
  input  wire logic [7:0]                   inv_gamma,
  input  wire logic [rgbg_pkg::RCP_W-1:0]   recip,
  input  wire logic                         bypass,
  output logic      [rgbg_pkg::CHAN_W-1:0]  chan_out
);
  import rgbg_pkg::*;

  localparam int PW = 9 + BOOST_W;
  localparam int BW = PW - BOOST_FRAC_BITS;

  logic [NUM_W-1:0] num_tab [256];
  for (genvar j = 0; j < 256; j++) begin : g_tab
    assign num_tab[j] = num_val(8'(j));
  end

  // raw channel travels along for bypass
  logic [7:0] c_d [LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      c_d[0] <= chan_in;
      for (int i = 1; i < LAT - 1; i++) c_d[i] <= c_d[i-1];
    end
  end

  // S1: stretch numerator
  logic [16:0]        prod1;
  logic [16:0]        sub1;
  logic signed [17:0] n1;
  logic [16:0]        n1_r;
  kind_t              kind1_r;
  logic [11:0]        bst1_r;
  assign prod1 = 17'(chan_in) * (17'd255 + 17'(low_cutoff));
  assign sub1  = 17'd255 * 17'(low_cutoff);
  assign n1    = $signed({1'b0, prod1}) - $signed({1'b0, sub1});
  always_ff @(posedge clk) begin
    if (en) begin
      n1_r    <= n1[16:0];
      kind1_r <= (n1 <= 18'sd0) ? KIND_ZERO : KIND_CALC;
      bst1_r  <= boost;
    end
  end

  // S2: divide by 255
  logic [35:0] q2;
  logic [8:0]  s2_r;
  kind_t       kind2_r;
  logic [11:0] bst2_r;
  assign q2 = 36'(n1_r) * 36'(DIV255_MUL);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r    <= q2[DIV255_SH +: 9];
      kind2_r <= kind1_r;
      bst2_r  <= bst1_r;
    end
  end

  // S3: boost and classify
  logic [PW-1:0] p3;
  logic [BW-1:0] b3;
  logic [7:0]    b3_r;
  kind_t         kind3_r;
  assign p3 = PW'(s2_r) * PW'(bst2_r);
  assign b3 = BW'(p3 >> BOOST_FRAC_BITS);
  always_ff @(posedge clk) begin
    if (en) begin
      b3_r <= b3[7:0];
      if (kind2_r == KIND_ZERO || b3 == '0) kind3_r <= KIND_ZERO;
      else if (b3 >= BW'(255))              kind3_r <= KIND_FULL;
      else                                  kind3_r <= KIND_CALC;
    end
  end

  // kind from here on is settled
  kind_t kind_d [LAT-4];
  always_ff @(posedge clk) begin
    if (en) begin
      kind_d[0] <= kind3_r;
      for (int i = 1; i < LAT - 4; i++) kind_d[i] <= kind_d[i-1];
    end
  end

  // S4: log difference table
  logic [NUM_W-1:0] num4_r;
  always_ff @(posedge clk) begin
    if (en) num4_r <= num_tab[b3_r];
  end

  // S5: quotient estimate by reciprocal
  logic [NUM_W+RCP_W-1:0] p5;
  logic [NUM_W-1:0]       q5_r;
  logic [NUM_W-1:0]       num5_r;
  assign p5 = (NUM_W + RCP_W)'(num4_r) * (NUM_W + RCP_W)'(recip);
  always_ff @(posedge clk) begin
    if (en) begin
      q5_r   <= p5[RCP_SH +: NUM_W];
      num5_r <= num4_r;
    end
  end

  // S6: back-multiply
  logic [NUM_W+7:0] qi6_r;
  logic [NUM_W-1:0] q6_r;
  logic [NUM_W-1:0] num6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      qi6_r  <= (NUM_W + 8)'(q5_r) * (NUM_W + 8)'(inv_gamma);
      q6_r   <= q5_r;
      num6_r <= num5_r;
    end
  end

  // S7: correct the estimate by one
  logic [NUM_W:0]   rem7;
  logic [NUM_W-1:0] e7_r;
  assign rem7 = {1'b0, num6_r} - qi6_r[NUM_W:0];
  always_ff @(posedge clk) begin
    if (en) e7_r <= q6_r + NUM_W'(rem7 >= (NUM_W + 1)'(inv_gamma));
  end

  // power stages: one root factor per stage
  logic [V_W-1:0]       v_d [ROOTS];
  logic [NUM_W-17:0]    k_d [ROOTS];
  logic [15:0]          f_d [ROOTS];
  for (genvar i = 0; i < ROOTS; i++) begin : g_pow
    localparam logic [29:0] ROOT = root_q30(i);
    logic [V_W-1:0]    v_in;
    logic [15:0]       f_in;
    logic [NUM_W-17:0] k_in;
    logic [V_W+29:0]   pm;
    if (i == 0) begin : g_first
      assign v_in = V_W'(1) << 30;
      assign f_in = e7_r[15:0];
      assign k_in = e7_r[NUM_W-1:16];
    end else begin : g_next
      assign v_in = v_d[i-1];
      assign f_in = f_d[i-1];
      assign k_in = k_d[i-1];
    end
    assign pm = (V_W + 30)'(v_in) * (V_W + 30)'(ROOT);
    always_ff @(posedge clk) begin
      if (en) begin
        v_d[i] <= f_in[15-i] ? pm[30 +: V_W] : v_in;
        f_d[i] <= f_in;
        k_d[i] <= k_in;
      end
    end
  end

  // integer part of the exponent
  logic [V_W-1:0] vs_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (k_d[ROOTS-1] >= (NUM_W - 16)'(31)) vs_r <= '0;
      else                                   vs_r <= v_d[ROOTS-1] >> k_d[ROOTS-1];
    end
  end

  // scale to 0..255 and pick the result
  logic [V_W+7:0] sc;
  logic [7:0]     out_r;
  assign sc = (V_W + 8)'(vs_r) * (V_W + 8)'(255);
  always_ff @(posedge clk) begin
    if (en) begin
      if (bypass)                          out_r <= c_d[LAT-2];
      else if (kind_d[LAT-5] == KIND_ZERO) out_r <= 8'd0;
      else if (kind_d[LAT-5] == KIND_FULL) out_r <= 8'd255;
      else                                 out_r <= sc[37:30];
    end
  end
  assign chan_out = out_r;

endmodule
`default_nettype wire

[rtl/rgb_gamma_stretch_correct_core.sv]
// ----------------------------------------------------------------------------
// rgb_gamma_stretch_correct_core: RGB stretch, boost and gamma corrector
// Pixels enter on in_ch with a Q4.8 boost and leave corrected on out_ch.
// inverse_gamma and low_cutoff are written over the cfg_ APB port at byte
// addresses 0 and 4; inverse_gamma of 0 or 255 passes pixels unchanged.
// One pixel is taken every cycle while the pipeline is not held; the three
// channels run side by side through a 25-stage pipeline: stretch, divide by
// 255, boost, log table, the reciprocal divide of the exponent, the 16
// root-factor multiply stages of the fractional power, shift and scale.
// A valid bit travels with each stage. When out_ch.ready is low and the
// last stage holds an item, the whole pipeline holds and in_ch.ready drops;
// bubbles still move forward while the last stage is empty.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// inverse_gamma to 255 and low_cutoff to 0. Write registers only while no
// item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module rgb_gamma_stretch_correct_core #(
  parameter int BOOST_FRAC_BITS = rgbg_pkg::BOOST_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rgbg_in_if.sink                           in_ch,
  rgbg_out_if.source                        out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [rgbg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [rgbg_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [rgbg_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import rgbg_pkg::*;

  logic [7:0]       inv_gamma_r;
  logic [7:0]       low_cutoff_r;
  logic [RCP_W-1:0] recip_r;
  logic             wr;
  logic             bypass;

  logic [RCP_W-1:0] rcp_tab [256];
  for (genvar j = 0; j < 256; j++) begin : g_rcp
    assign rcp_tab[j] = recip_val(8'(j));
  end

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_gamma_r  <= 8'd255;
      low_cutoff_r <= 8'd0;
    end else if (wr) begin
      case (cfg_paddr[2])
        REG_INV_GAMMA:  inv_gamma_r  <= cfg_pwdata[7:0];
        REG_LOW_CUTOFF: low_cutoff_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    recip_r <= rcp_tab[inv_gamma_r];
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_INV_GAMMA:  cfg_prdata = {24'd0, inv_gamma_r};
      REG_LOW_CUTOFF: cfg_prdata = {24'd0, low_cutoff_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign bypass = (inv_gamma_r == 8'd0) || (inv_gamma_r == 8'd255);

  // advance when the last stage is empty or being taken
  logic           adv;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;
  assign adv     = !vld_r[LAT-1] || out_ch.ready;
  assign vld_nxt = {vld_r[LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[LAT-1];

  rgbg_chan #(.BOOST_FRAC_BITS(BOOST_FRAC_BITS)) u_red (
    .clk(clk), .en(adv), .chan_in(in_ch.red_in), .boost(in_ch.boost),
    .low_cutoff(low_cutoff_r), .inv_gamma(inv_gamma_r), .recip(recip_r),
    .bypass(bypass), .chan_out(out_ch.red_out)
  );

  rgbg_chan #(.BOOST_FRAC_BITS(BOOST_FRAC_BITS)) u_green (
    .clk(clk), .en(adv), .chan_in(in_ch.green_in), .boost(in_ch.boost),
    .low_cutoff(low_cutoff_r), .inv_gamma(inv_gamma_r), .recip(recip_r),
    .bypass(bypass), .chan_out(out_ch.green_out)
  );

  rgbg_chan #(.BOOST_FRAC_BITS(BOOST_FRAC_BITS)) u_blue (
    .clk(clk), .en(adv), .chan_in(in_ch.blue_in), .boost(in_ch.boost),
    .low_cutoff(low_cutoff_r), .inv_gamma(inv_gamma_r), .recip(recip_r),
    .bypass(bypass), .chan_out(out_ch.blue_out)
  );

endmodule
`default_nettype wire
